// File: rtl/ppid_pkg.sv
// Shared types and constants for the positional PID block with integral clamp.
// Used by the top level and by its port checker; depends on nothing else.

package ppid_pkg;

    // Field and register widths
    localparam int GAIN_W  = 16;
    localparam int POS_W   = 16;
    localparam int ERR_W   = 18;
    localparam int PROD_W  = GAIN_W + ERR_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FRAC_W  = 8;
    localparam int DRIVE_W = 28;
    localparam int S_DATA_W = 2 * POS_W;
    localparam int M_DATA_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 2'd3;

    // Integral clamp default after reset
    localparam logic [CFG_DATA_W-1:0] INT_LIMIT_RESET = 16'd970;

    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;

endpackage

// File: rtl/positional_pid_integral_clamp_top.sv
// Positional PID controller with a clamped integral: three-stage pipeline.
// Depends on ppid_pkg for widths, types and register indexes.
//
// Usage:
//   s_ channel: one control tick per transfer; s_tdata carries the encoder
//   position and the target. m_ channel: one drive value per tick, in order.
//   cfg channel: writes gain_p, gain_i, gain_d (signed Q8.8) and
//   integral_limit by index; cfg_ready is always high. Write only while idle.
//   Throughput: one tick per cycle while no stall holds the pipeline. The
//   error, the clamped integral and the derivative term are formed in the
//   first stage, where the integral/previous-error loop closes; the three
//   16x18 products take the second; the sum and the floor shift by 8 the
//   third, into the output register.
//   A stall on m_tready holds the output register; each stage ahead of it
//   keeps taking ticks until it is full, then s_tready drops.
//   Reset (aresetn low, synchronous) empties the pipeline, zeroes the
//   integral, the previous error and the gains, and sets the limit to 970.

module positional_pid_integral_clamp_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: [15:0] measured_position, [31:16] target_position
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppid_pkg::S_DATA_W-1:0]    s_tdata,
    // m_tdata: [27:0] drive_value, [31:28] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppid_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppid_pkg::*;

    // Configuration registers
    gain_t                 gain_p_reg, gain_i_reg, gain_d_reg;
    logic [CFG_DATA_W-1:0] int_limit_reg;

    // Controller state
    err_t error_sum_reg, error_sum_next;
    err_t prev_err_reg;

    // Stage 1: error terms
    logic s1_valid_reg;
    err_t err_reg, err_next;
    err_t acc_reg;
    err_t diff_reg, diff_next;

    // Stage 2: products
    logic  s2_valid_reg;
    prod_t prod_p_reg, prod_p_next;
    prod_t prod_i_reg, prod_i_next;
    prod_t prod_d_reg, prod_d_next;

    // Stage 3: output register
    logic   out_valid_reg;
    drive_t drive_reg, drive_next;

    // Working signals for stage 1
    pos_t meas_pos;
    pos_t meas_neg;
    pos_t target_pos;
    logic [POS_W-2:0] meas_mag;
    err_t acc_raw;
    err_t limit_pos;
    err_t limit_neg;
    sum_t sum_all;

    logic adv_out, adv_s2, adv_s1, take_in, cfg_fire;

    // Advance each stage when it is empty or its successor moves
    assign adv_out  = !out_valid_reg || m_tready;
    assign adv_s2   = !s2_valid_reg || adv_out;
    assign adv_s1   = !s1_valid_reg || adv_s2;
    assign s_tready = adv_s1;
    assign take_in  = s_tvalid && adv_s1;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Error, clamped integral and derivative difference
    always_comb begin
        meas_pos   = pos_t'(s_tdata[POS_W-1:0]);
        target_pos = pos_t'(s_tdata[S_DATA_W-1:POS_W]);
        meas_neg   = -meas_pos;
        // Magnitude; the most negative position saturates to the largest positive
        if (meas_pos == {1'b1, {(POS_W-1){1'b0}}}) begin
            meas_mag = {(POS_W-1){1'b1}};
        end else if (meas_pos[POS_W-1]) begin
            meas_mag = meas_neg[POS_W-2:0];
        end else begin
            meas_mag = meas_pos[POS_W-2:0];
        end
        err_next  = err_t'(target_pos) - err_t'({1'b0, meas_mag});
        acc_raw   = error_sum_reg + err_next;
        limit_pos = err_t'({1'b0, int_limit_reg});
        limit_neg = -limit_pos;
        if (acc_raw > limit_pos) begin
            error_sum_next = limit_pos;
        end else if (acc_raw < limit_neg) begin
            error_sum_next = limit_neg;
        end else begin
            error_sum_next = acc_raw;
        end
        diff_next = err_next - prev_err_reg;
    end

    // Three parallel products of Q8.8 gains
    always_comb begin
        prod_p_next = prod_t'(gain_p_reg) * prod_t'(err_reg);
        prod_i_next = prod_t'(gain_i_reg) * prod_t'(acc_reg);
        prod_d_next = prod_t'(gain_d_reg) * prod_t'(diff_reg);
    end

    // Sum and floor shift by the fraction width
    always_comb begin
        sum_all    = sum_t'(prod_p_reg) + sum_t'(prod_i_reg) + sum_t'(prod_d_reg);
        drive_next = drive_t'(sum_all[SUM_W-1:FRAC_W]);
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            int_limit_reg <= INT_LIMIT_RESET;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= gain_t'(cfg_data);
                REG_GAIN_I:    gain_i_reg    <= gain_t'(cfg_data);
                REG_GAIN_D:    gain_d_reg    <= gain_t'(cfg_data);
                REG_INT_LIMIT: int_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Controller state: update on every accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end else if (take_in) begin
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= err_next;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv_s1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv_s2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (take_in) begin
            err_reg  <= err_next;
            acc_reg  <= error_sum_next;
            diff_reg <= diff_next;
        end
        if (adv_s2 && s1_valid_reg) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (adv_out && s2_valid_reg) begin
            drive_reg <= drive_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-DRIVE_W){1'b0}}, drive_reg};

endmodule

// File: rtl/ppid_checker.sv
// Port-level checks for the positional PID top level, bound to it below.
// Depends on ppid_pkg for port widths.

module ppid_port_checks (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ppid_pkg::M_DATA_W-1:0]    m_tdata
);
    import ppid_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A held result keeps its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Padding above the drive value stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:DRIVE_W] == '0)
        else $error("m_tdata padding not zero");

    // An accepted tick shows a result within the pipeline depth
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##3 m_tvalid)
        else $error("no result three cycles after a transfer");

endmodule

bind positional_pid_integral_clamp_top ppid_port_checks u_ppid_port_checks (.*);
